>>> rtl/core/ldet_pkg.sv
// Shared types and constants for the landing detector.
package ldet_pkg;

  localparam int COUNT_BITS = 24;
  localparam int THR_BITS   = 11;
  localparam int SUM_BITS   = THR_BITS + COUNT_BITS;
  localparam int PROD_BITS  = THR_BITS + 1 + COUNT_BITS;
  localparam int DELAY_BITS = 16;

  localparam int IN_DATA_BITS  = 112;
  localparam int OUT_DATA_BITS = 8;

  localparam logic [31:0]           WAIT_US        = 32'd1000000;
  localparam logic signed [15:0]    VERT_LIMIT     = 16'sd400;
  localparam logic [15:0]           HORIZ_LIMIT    = 16'd1600;
  localparam logic [THR_BITS:0]     THR_MARGIN_P1  = (THR_BITS + 1)'(41);
  localparam logic signed [16:0]    SURFACE_MARGIN = 17'sd80;
  localparam logic [9:0]            MS_TO_US       = 10'd1000;
  localparam logic [DELAY_BITS-1:0] DISARM_RESET   = 16'd2000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;

  localparam int OUT_LANDED   = 0;
  localparam int OUT_POSSIBLE = 1;
  localparam int OUT_MINIMAL  = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MULT,
    ST_DECIDE
  } ldet_state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic mult;
    logic decide;
  } ldet_ctl_t;

  typedef struct packed {
    logic out_busy;
  } ldet_status_t;

endpackage

>>> rtl/core/ldet_ctrl.sv
// Sequencer that steps one word through capture, update, multiply and decide.
module ldet_ctrl
  import ldet_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  ldet_status_t status,
  output ldet_ctl_t    ctl
);

  ldet_state_t state;
  ldet_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_MULT;
      ST_MULT:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
        ctl.load = s_tvalid && !rst;
      end
      ST_UPDATE: ctl.update = 1'b1;
      ST_MULT:   ctl.mult   = 1'b1;
      ST_DECIDE: ctl.decide = !status.out_busy;
      default: ctl = '0;
    endcase
  end

  a_load_to_update: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (state == ST_UPDATE && ctl.update))
    else $error("captured word did not advance to update");

  a_decide_free: assert property (@(posedge clk) disable iff (rst)
    ctl.decide |-> !status.out_busy)
    else $error("decide issued while result register still held");

endmodule

>>> rtl/core/ldet_datapath.sv
// Detector state, average test, hold timer and result register.
module ldet_datapath
  import ldet_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ldet_ctl_t                ctl,
  output ldet_status_t             status,
  input  logic                     cfg_we,
  input  logic [DELAY_BITS-1:0]    cfg_wdata,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  logic [DELAY_BITS-1:0] disarm_delay_ms;

  logic                 cmd_reset;
  logic [31:0]          now_us;
  logic signed [15:0]   vertical_velocity;
  logic [15:0]          horizontal_speed;
  logic [THR_BITS-1:0]  adjusted_throttle;
  logic                 surface_valid;
  logic signed [15:0]   surface_height;
  logic signed [15:0]   surface_minimum;

  logic [31:0]          start_time;
  logic                 started;
  logic [31:0]          hold_timer_start;
  logic [SUM_BITS-1:0]  throttle_sum;
  logic [COUNT_BITS-1:0] sample_count;

  logic                 in_window;
  logic                 motion_ok;
  logic [31:0]          delay_us;
  logic [PROD_BITS-1:0] avg_bound;
  logic                 count_nz;

  logic                 minimal;
  logic                 possible;
  logic                 landed;
  logic                 elapsed_long;
  logic                 surf_ok;
  logic signed [16:0]   surf_limit;

  logic                 out_valid;
  logic [2:0]           out_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      disarm_delay_ms <= DISARM_RESET;
    end else if (cfg_we) begin
      disarm_delay_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_reset         <= s_tuser;
      now_us            <= s_tdata[31:0];
      vertical_velocity <= s_tdata[47:32];
      horizontal_speed  <= s_tdata[63:48];
      adjusted_throttle <= s_tdata[74:64];
      surface_valid     <= s_tdata[75];
      surface_height    <= s_tdata[91:76];
      surface_minimum   <= s_tdata[107:92];
    end
  end

  assign surf_limit = 17'(surface_minimum) + SURFACE_MARGIN;
  assign surf_ok    = !(surface_valid && !surface_minimum[15]) ||
                      (17'(surface_height) <= surf_limit);

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      in_window <= !cmd_reset && started && ((now_us - start_time) > WAIT_US);
      motion_ok <= (vertical_velocity >= -VERT_LIMIT) &&
                   (vertical_velocity <= VERT_LIMIT) &&
                   (horizontal_speed <= HORIZ_LIMIT) && surf_ok;
      delay_us  <= 32'(disarm_delay_ms) * 32'(MS_TO_US);
    end
    if (ctl.mult) begin
      avg_bound <= PROD_BITS'({1'b0, adjusted_throttle} + THR_MARGIN_P1) *
                   PROD_BITS'(sample_count);
      count_nz  <= (sample_count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time       <= '0;
      started          <= 1'b0;
      hold_timer_start <= '0;
      throttle_sum     <= '0;
      sample_count     <= '0;
    end else if (ctl.update && !cmd_reset) begin
      if (!started) begin
        started    <= 1'b1;
        start_time <= now_us;
      end else if (((now_us - start_time) > WAIT_US) && (sample_count != COUNT_MAX)) begin
        sample_count <= sample_count + 1'b1;
        throttle_sum <= throttle_sum + SUM_BITS'(adjusted_throttle);
      end
    end else if (ctl.decide) begin
      if (cmd_reset) begin
        hold_timer_start <= now_us;
        started          <= 1'b0;
        throttle_sum     <= '0;
        sample_count     <= '0;
      end else if (!possible) begin
        hold_timer_start <= now_us;
      end
    end
  end

  assign minimal      = in_window && count_nz && (PROD_BITS'(throttle_sum) >= avg_bound);
  assign possible     = minimal && motion_ok;
  assign elapsed_long = (now_us - hold_timer_start) > delay_us;
  assign landed       = possible && elapsed_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.decide) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.decide) begin
      out_bits[OUT_LANDED]   <= !cmd_reset && landed;
      out_bits[OUT_POSSIBLE] <= !cmd_reset && possible;
      out_bits[OUT_MINIMAL]  <= !cmd_reset && minimal;
    end
  end

  assign status.out_busy = out_valid && !m_tready;
  assign m_tvalid        = out_valid;
  assign m_tdata         = {(OUT_DATA_BITS - 3)'(0), out_bits};

  a_landed_needs_possible: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_bits[OUT_LANDED] || out_bits[OUT_POSSIBLE]))
    else $error("landed reported without possible landing");

  a_possible_needs_minimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_bits[OUT_POSSIBLE] || out_bits[OUT_MINIMAL]))
    else $error("possible landing reported without minimal thrust");

  a_reset_word_clears: assert property (@(posedge clk) disable iff (rst)
    (ctl.decide && cmd_reset) |=> (out_bits == '0 && sample_count == '0 && !started))
    else $error("reset word left state or result set");

endmodule

>>> rtl/core/landing_detector_core.sv
// Top level of the landing detector: sequencer plus datapath.
//
//  channel  dir  handshake                 payload
//  s        in   s_tvalid / s_tready       s_tdata (sample), s_tuser (reset word)
//  m        out  m_tvalid / m_tready       m_tdata (landed, possible, minimal)
//  cfg      in   cfg_we                    cfg_wdata (disarm delay, ms)
//
// A word is captured at accept; its result is registered after state update, the
// sum-versus-count product for the average test, and decide.
// The next word is accepted on the cycle after decide, while the result waits,
// so words go one at a time. A result not taken holds the sequencer in decide.
// rst clears detector state and the result valid flag and loads a 2000 ms delay.
module landing_detector_core
  import ldet_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // [31:0] now_us, [47:32] vertical_velocity, [63:48] horizontal_speed,
  // [74:64] adjusted_throttle, [75] surface_valid, [91:76] surface_height,
  // [107:92] surface_minimum, [111:108] zero
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // [0] cmd
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // [0] landed, [1] possible_landing, [2] minimal_thrust, [7:3] zero
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  input  logic                     cfg_we,
  input  logic [DELAY_BITS-1:0]    cfg_wdata
);

  ldet_ctl_t    ctl;
  ldet_status_t status;

  ldet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .ctl      (ctl)
  );

  ldet_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
